// ----- src/mgh_pkg.sv -----
// shared types and constants of the multiplicity gated histogrammer
package mgh_pkg;

  // detector and histogram geometry, fixed by the field widths below
  localparam int unsigned WINDOW_WIDTH  = 16;
  localparam int unsigned SIDE_CHANNELS = 64;
  localparam int unsigned NUM_BINS      = 500;

  // configuration register indexes
  localparam logic [1:0] CFG_X_WINDOW  = 2'd0;
  localparam logic [1:0] CFG_Y_WINDOW  = 2'd1;
  localparam logic [1:0] CFG_THRESHOLD = 2'd2;
  localparam logic [1:0] CFG_OFFSET    = 2'd3;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // register reset values
  localparam logic [5:0]  X_WINDOW_RST  = 6'd48;
  localparam logic [6:0]  Y_WINDOW_RST  = 7'd112;
  localparam logic [15:0] THRESHOLD_RST = 16'd50;
  localparam logic [15:0] OFFSET_RST    = 16'd10;

  // histogram set codes
  localparam logic [1:0] SET_WINDOW = 2'd0;
  localparam logic [1:0] SET_SIDE   = 2'd1;
  localparam logic [1:0] SET_RAW    = 2'd2;

  // request kinds
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_READ   = 1'b1;

  // bin width is a power of two
  localparam int unsigned BIN_SHIFT = 2;

  // hit counter saturation limits
  localparam logic [6:0] SIDE_HITS_MAX   = 7'd127;
  localparam logic [4:0] WINDOW_HITS_MAX = 5'd31;

  typedef struct packed {
    logic        req_type;
    logic [6:0]  channel;
    logic [15:0] energy;
    logic        last_channel;
    logic [1:0]  hist_select;
    logic [4:0]  hist_index;
    logic [8:0]  bin_index;
  } req_t;

  typedef struct packed {
    logic [31:0] bin_count;
  } rsp_t;

  typedef enum logic [1:0] {
    ADDR_REQ,
    ADDR_WIN,
    ADDR_SIDE
  } addr_sel_e;

  // controller to datapath
  typedef struct packed {
    logic      take;       // request accepted this cycle
    logic      hist_re;    // read a histogram bin
    addr_sel_e addr_sel;
    logic      hist_we;    // write back the incremented bin
    logic      clr_we;     // clearing pass write
    logic      en_re;      // read buffered window energy of slot k
    logic      k_inc;
    logic      end_clear;  // drop slot valids and hit counters
    logic      out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic in_read;
    logic in_last;
    logic in_slot_hit;
    logic last_q;
    logic k_valid;
    logic k_last;
    logic win_one;
    logic side_one;
    logic out_free;
  } sts_t;

endpackage

// ----- src/mgh_req_if.sv -----
// request channel of the histogrammer
interface mgh_req_if;
  logic          valid;
  logic          ready;
  mgh_pkg::req_t payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

// ----- src/mgh_rsp_if.sv -----
// result channel of the histogrammer
interface mgh_rsp_if;
  logic          valid;
  logic          ready;
  mgh_pkg::rsp_t payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

// ----- src/mgh_ram.sv -----
// generic single write port ram with registered read
module mgh_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/mgh_ctrl.sv -----
// sequencing of sample updates, reads, event end sweep and clearing pass
module mgh_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  mgh_pkg::sts_t sts_i,
  output mgh_pkg::cmd_t cmd_o
);
  import mgh_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RAW_WR,
    ST_RD_OUT,
    ST_E_LOAD,
    ST_WIN_RD,
    ST_WIN_WR,
    ST_SIDE_RD,
    ST_SIDE_WR
  } state_e;

  state_e state_q, state_d;
  logic   fire;

  assign in_ready_o = (state_q == ST_IDLE);
  assign fire       = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o          = '0;
    cmd_o.addr_sel = ADDR_REQ;
    cmd_o.take     = fire;
    state_d        = state_q;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_we = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (fire) begin
          if (sts_i.in_read) begin
            cmd_o.hist_re = 1'b1;
            state_d       = ST_RD_OUT;
          end else if (sts_i.in_slot_hit) begin
            cmd_o.hist_re = 1'b1;
            state_d       = ST_RAW_WR;
          end else if (sts_i.in_last) begin
            state_d = ST_E_LOAD;
          end
        end
      end
      ST_RAW_WR: begin
        cmd_o.hist_we = 1'b1;
        state_d       = sts_i.last_q ? ST_E_LOAD : ST_IDLE;
      end
      ST_RD_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_E_LOAD: begin
        if (sts_i.k_valid) begin
          cmd_o.en_re = 1'b1;
          state_d     = ST_WIN_RD;
        end else if (sts_i.k_last) begin
          cmd_o.end_clear = 1'b1;
          state_d         = ST_IDLE;
        end else begin
          cmd_o.k_inc = 1'b1;
        end
      end
      ST_WIN_RD: begin
        if (sts_i.win_one) begin
          cmd_o.hist_re  = 1'b1;
          cmd_o.addr_sel = ADDR_WIN;
          state_d        = ST_WIN_WR;
        end else begin
          state_d = ST_SIDE_RD;
        end
      end
      ST_WIN_WR: begin
        cmd_o.hist_we = 1'b1;
        state_d       = ST_SIDE_RD;
      end
      ST_SIDE_RD: begin
        if (sts_i.side_one) begin
          cmd_o.hist_re  = 1'b1;
          cmd_o.addr_sel = ADDR_SIDE;
          state_d        = ST_SIDE_WR;
        end else if (sts_i.k_last) begin
          cmd_o.end_clear = 1'b1;
          state_d         = ST_IDLE;
        end else begin
          cmd_o.k_inc = 1'b1;
          state_d     = ST_E_LOAD;
        end
      end
      ST_SIDE_WR: begin
        cmd_o.hist_we = 1'b1;
        if (sts_i.k_last) begin
          cmd_o.end_clear = 1'b1;
          state_d         = ST_IDLE;
        end else begin
          cmd_o.k_inc = 1'b1;
          state_d     = ST_E_LOAD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- src/mgh_dp.sv -----
// datapath: config registers, hit counters, window buffer, histogram memory
module mgh_dp #(
  parameter int unsigned COUNT_WIDTH   = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mgh_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [mgh_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  mgh_pkg::req_t                   req_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output mgh_pkg::rsp_t                   rsp_o,
  input  mgh_pkg::cmd_t                   cmd_i,
  output mgh_pkg::sts_t                   sts_o
);
  import mgh_pkg::*;

  localparam int unsigned SLOTS    = 2 * WINDOW_WIDTH;
  localparam int unsigned SLOT_W   = $clog2(SLOTS);
  localparam int unsigned BINS_ALL = NUM_BINS + 2;
  localparam int unsigned BIN_W    = $clog2(BINS_ALL);
  localparam int unsigned ROWS     = 3 * SLOTS;
  localparam int unsigned ROW_W    = $clog2(ROWS);
  localparam int unsigned DEPTH    = ROWS * BINS_ALL;
  localparam int unsigned AW       = $clog2(DEPTH);
  localparam int unsigned CW       = COUNT_WIDTH;

  // configuration
  logic [5:0]  xws_q;
  logic [6:0]  yws_q;
  logic [15:0] thr_q;
  logic [15:0] off_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xws_q <= X_WINDOW_RST;
      yws_q <= Y_WINDOW_RST;
      thr_q <= THRESHOLD_RST;
      off_q <= OFFSET_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_X_WINDOW:  xws_q <= cfg_data_i[5:0];
        CFG_Y_WINDOW:  yws_q <= cfg_data_i[6:0];
        CFG_THRESHOLD: thr_q <= cfg_data_i;
        CFG_OFFSET:    off_q <= cfg_data_i;
        default:       ;
      endcase
    end
  end

  function automatic logic [BIN_W-1:0] bin_of(input logic [15:0] e, input logic [15:0] off);
    logic [13:0] d;
    logic [15:0] diff;
    begin
      diff = e - off;
      d    = diff[15:BIN_SHIFT];
      if (e < off) begin
        bin_of = '0;
      end else if (32'(d) >= 32'(NUM_BINS)) begin
        bin_of = BIN_W'(NUM_BINS + 1);
      end else begin
        bin_of = BIN_W'(32'(d) + 32'd1);
      end
    end
  endfunction

  // sample classification
  logic [9:0]        ch_w;
  logic              hit;
  logic              first_side, second_side, in_x, in_y, slot_hit;
  logic [SLOT_W-1:0] slot;
  logic [9:0]        x_rel, y_rel;

  assign ch_w        = 10'(req_i.channel);
  assign hit         = req_i.energy > thr_q;
  assign first_side  = ch_w < 10'(SIDE_CHANNELS);
  assign second_side = !first_side && (ch_w < 10'(2 * SIDE_CHANNELS));
  assign in_x        = first_side && (ch_w >= 10'(xws_q))
                       && (ch_w < 10'(xws_q) + 10'(WINDOW_WIDTH));
  assign in_y        = second_side && (ch_w >= 10'(yws_q))
                       && (ch_w < 10'(yws_q) + 10'(WINDOW_WIDTH));
  assign x_rel       = ch_w - 10'(xws_q);
  assign y_rel       = ch_w - 10'(yws_q) + 10'(WINDOW_WIDTH);
  assign slot        = in_x ? x_rel[SLOT_W-1:0] : y_rel[SLOT_W-1:0];
  assign slot_hit    = in_x || in_y;

  logic sample_take;
  assign sample_take = cmd_i.take && (req_i.req_type == REQ_SAMPLE);

  // hit counters, slot valids, sweep index
  logic [6:0]        fsh_q, ssh_q;
  logic [4:0]        fwh_q, swh_q;
  logic [SLOTS-1:0]  valid_q;
  logic [SLOT_W-1:0] k_q;
  logic              last_q;
  logic              rd_bad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsh_q    <= '0;
      ssh_q    <= '0;
      fwh_q    <= '0;
      swh_q    <= '0;
      valid_q  <= '0;
      k_q      <= '0;
      last_q   <= 1'b0;
      rd_bad_q <= 1'b0;
    end else begin
      if (cmd_i.end_clear) begin
        fsh_q   <= '0;
        ssh_q   <= '0;
        fwh_q   <= '0;
        swh_q   <= '0;
        valid_q <= '0;
        k_q     <= '0;
      end else begin
        if (cmd_i.k_inc) begin
          k_q <= k_q + 1'b1;
        end
        if (sample_take) begin
          if (hit && first_side && fsh_q != SIDE_HITS_MAX) begin
            fsh_q <= fsh_q + 1'b1;
          end
          if (hit && second_side && ssh_q != SIDE_HITS_MAX) begin
            ssh_q <= ssh_q + 1'b1;
          end
          if (hit && in_x && fwh_q != WINDOW_HITS_MAX) begin
            fwh_q <= fwh_q + 1'b1;
          end
          if (hit && in_y && swh_q != WINDOW_HITS_MAX) begin
            swh_q <= swh_q + 1'b1;
          end
          if (slot_hit) begin
            valid_q[slot] <= 1'b1;
          end
        end
      end
      if (cmd_i.take) begin
        last_q   <= req_i.last_channel;
        rd_bad_q <= (req_i.hist_select > SET_RAW)
                    || (32'(req_i.hist_index) >= 32'(SLOTS))
                    || (32'(req_i.bin_index) >= 32'(BINS_ALL));
      end
    end
  end

  // window energy buffer
  logic [15:0] en_rdata;

  mgh_ram #(.WIDTH(16), .DEPTH(SLOTS)) u_en_ram (
    .clk_i   (clk_i),
    .we_i    (sample_take && slot_hit),
    .waddr_i (slot),
    .wdata_i (req_i.energy),
    .re_i    (cmd_i.en_re),
    .raddr_i (k_q),
    .rdata_o (en_rdata)
  );

  // histogram address
  logic [ROW_W-1:0] row;
  logic [AW-1:0]    bin_a;
  logic [AW-1:0]    addr;
  logic [BIN_W-1:0] sweep_bin;

  assign sweep_bin = bin_of(en_rdata, off_q);

  always_comb begin
    row   = '0;
    bin_a = '0;
    case (cmd_i.addr_sel)
      ADDR_REQ: begin
        if (req_i.req_type == REQ_READ) begin
          row   = ROW_W'(ROW_W'(req_i.hist_select) * ROW_W'(SLOTS))
                  + ROW_W'(req_i.hist_index);
          bin_a = AW'(req_i.bin_index);
        end else begin
          row   = ROW_W'(2 * SLOTS) + ROW_W'(slot);
          bin_a = AW'(bin_of(req_i.energy, off_q));
        end
      end
      ADDR_WIN: begin
        row   = ROW_W'(k_q);
        bin_a = AW'(sweep_bin);
      end
      ADDR_SIDE: begin
        row   = ROW_W'(SLOTS) + ROW_W'(k_q);
        bin_a = AW'(sweep_bin);
      end
      default: begin
        row   = '0;
        bin_a = '0;
      end
    endcase
    addr = AW'(AW'(row) * AW'(BINS_ALL)) + bin_a;
  end

  // clearing pass and read-modify-write
  logic [AW-1:0]  clr_q;
  logic [AW-1:0]  addr_q;
  logic [CW-1:0]  h_rdata;
  logic [CW-1:0]  h_inc;
  logic           h_we;
  logic [AW-1:0]  h_waddr;
  logic [CW-1:0]  h_wdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_we) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.hist_re) begin
      addr_q <= addr;
    end
  end

  assign h_inc   = (h_rdata == {CW{1'b1}}) ? h_rdata : h_rdata + 1'b1;
  assign h_we    = cmd_i.hist_we || cmd_i.clr_we;
  assign h_waddr = cmd_i.clr_we ? clr_q : addr_q;
  assign h_wdata = cmd_i.clr_we ? '0 : h_inc;

  mgh_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (h_we),
    .waddr_i (h_waddr),
    .wdata_i (h_wdata),
    .re_i    (cmd_i.hist_re),
    .raddr_i (addr),
    .rdata_o (h_rdata)
  );

  // result register, saturated to the output width
  logic [CW+31:0] cnt_ext;
  logic [31:0]    cnt_sat;
  logic           out_valid_q;
  logic [31:0]    out_q;

  assign cnt_ext = {32'd0, h_rdata};
  assign cnt_sat = (|cnt_ext[CW+31:32]) ? 32'hFFFF_FFFF : cnt_ext[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= rd_bad_q ? 32'd0 : cnt_sat;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign rsp_o.bin_count = out_q;

  // status
  logic k_first;
  assign k_first = 32'(k_q) < 32'(WINDOW_WIDTH);

  assign sts_o.clr_last    = (32'(clr_q) == DEPTH - 1);
  assign sts_o.in_read     = (req_i.req_type == REQ_READ);
  assign sts_o.in_last     = req_i.last_channel;
  assign sts_o.in_slot_hit = slot_hit;
  assign sts_o.last_q      = last_q;
  assign sts_o.k_valid     = valid_q[k_q];
  assign sts_o.k_last      = (32'(k_q) == SLOTS - 1);
  assign sts_o.win_one     = k_first ? (fwh_q == 5'd1) : (swh_q == 5'd1);
  assign sts_o.side_one    = k_first ? (fsh_q == 7'd1) : (ssh_q == 7'd1);
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

endmodule

// ----- src/multiplicity_gated_histogrammer.sv -----
// top level: strip histogrammer gated on side and window hit multiplicity
// a sample outside the windows is taken in idle, a window sample adds a raw bin read then write
// a read reads its bin as the request is taken and loads the count into the output register
// in the read-out state, waiting there while that register still holds an unaccepted count
// event end sweeps all window slots: an empty slot is stepped over, a filled slot goes through
// an energy buffer read, then one read-modify-write per gated histogram
// reset runs a clearing pass over all 3*2*WINDOW_WIDTH*(NUM_BINS+2) bins, 48192 at defaults
module multiplicity_gated_histogrammer #(
  parameter int unsigned COUNT_WIDTH   = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration writes, taken in any state
  input  logic                           cfg_we_i,
  input  logic [mgh_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mgh_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // sample and bin read requests
  mgh_req_if.sink                        req_i,
  // bin counts of read requests
  mgh_rsp_if.source                      rsp_o
);
  import mgh_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: clearing pass, per-request steps, event end sweep
  mgh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // registers, counters, energy buffer and histogram memory
  mgh_dp #(
    .COUNT_WIDTH   (COUNT_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .req_i       (req_i.payload),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .rsp_o       (rsp_o.payload),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
